// File: src/image_size_header_parser_defines.svh
// Assertion macros shared by the image size header parser checker.
`ifndef IMAGE_SIZE_HEADER_PARSER_DEFINES_SVH
`define IMAGE_SIZE_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define IMSZ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imsz check failed");

// Next-cycle implication, disabled while reset is low.
`define IMSZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imsz check failed");

`endif

// File: src/imsz_pkg.sv
// Types and constants of the image size header parser.
`default_nettype none

package imsz_pkg;

    // Parser phase
    typedef enum logic [3:0] {
        PH_SIG      = 4'd0,
        PH_GIF      = 4'd1,
        PH_PNG_SIG  = 4'd2,
        PH_PNG_DIM  = 4'd3,
        PH_J_SEEK   = 4'd4,
        PH_J_MARK   = 4'd5,
        PH_J_LEN_HI = 4'd6,
        PH_J_LEN_LO = 4'd7,
        PH_J_SKIP   = 4'd8,
        PH_J_SOF    = 4'd9,
        PH_DONE     = 4'd10
    } t_phase;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNKNOWN  = 3'd1;
    localparam logic [2:0] ST_PNG_BAD  = 3'd2;
    localparam logic [2:0] ST_NO_FRAME = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;
    localparam logic [2:0] ST_BAD_LEN  = 3'd5;

    // Image kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_GIF  = 2'd1;
    localparam logic [1:0] KIND_JPEG = 2'd2;
    localparam logic [1:0] KIND_PNG  = 2'd3;

    // Three-byte signatures
    localparam logic [23:0] SIG_GIF  = 24'h474946;
    localparam logic [23:0] SIG_JPEG = 24'hFFD8FF;
    localparam logic [23:0] SIG_PNG  = 24'h89504E;

    // JPEG markers
    localparam logic [7:0] MK_FILL = 8'hFF;
    localparam logic [7:0] MK_EOI  = 8'hD9;
    localparam logic [7:0] MK_SOS  = 8'hDA;

    // Output payload packing
    localparam int unsigned OUT_BITS  = 69;
    localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

    // Full eight-byte PNG signature
    function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h89;
            3'd1:    v = 8'h50;
            3'd2:    v = 8'h4E;
            3'd3:    v = 8'h47;
            3'd4:    v = 8'h0D;
            3'd5:    v = 8'h0A;
            3'd6:    v = 8'h1A;
            default: v = 8'h0A;
        endcase
        return v;
    endfunction

    // SOFn: C0..CF except DHT (C4), JPG (C8) and DAC (CC)
    function automatic logic is_sof(input logic [7:0] m);
        return (m[7:4] == 4'hC) && (m[3:0] != 4'h4) && (m[3:0] != 4'h8)
               && (m[3:0] != 4'hC);
    endfunction

endpackage

`default_nettype wire

// File: src/image_size_header_parser.sv
// Byte-stream parser that reports GIF, JPEG or PNG image dimensions.
// The result is registered: it is valid in the cycle after the byte that decides it is accepted.
// Throughput: one byte per cycle; the only stall is a full result register.
// The result register drains while the next byte is taken in the same cycle.
// Reset (synchronous, active low) returns the parser to signature search
// and empties the result register.
`default_nettype none

module image_size_header_parser (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // Input request stream
    input  wire                             i_s_tvalid,
    output logic                            o_s_tready,
    input  wire  [7:0]                      i_s_tdata,   // [7:0] data_byte
    input  wire                             i_s_tlast,   // last_byte
    // Result stream
    output logic                            o_m_tvalid,
    input  wire                             i_m_tready,
    output logic [imsz_pkg::OUT_BYTES*8-1:0] o_m_tdata   // [2:0] status, [4:3] image_kind,
                                                         // [36:5] width, [68:37] height
);
    import imsz_pkg::*;

    // Parser state
    t_phase      r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic [1:0]  r_kind, n_kind;
    logic [31:0] r_wacc, n_wacc;
    logic [31:0] r_hacc, n_hacc;
    logic [15:0] r_seg, n_seg;
    logic        r_sent, n_sent;

    // Result register
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_out_status;
    logic [1:0]  r_out_kind;
    logic [31:0] r_out_width;
    logic [31:0] r_out_height;

    // Per-byte decode results
    logic        acc;
    logic        fire;
    logic        take_emit;
    logic [2:0]  take_status;
    logic [2:0]  fire_status;
    logic        no_inc;
    logic [7:0]  b;
    logic [31:0] sig_shift;
    logic [15:0] seg_len;
    logic [15:0] seg_left;
    logic [15:0] seg_dec;
    logic [1:0]  res_kind;
    logic [31:0] res_width;
    logic [31:0] res_height;

    assign b          = i_s_tdata;
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign acc        = i_s_tvalid && o_s_tready;
    assign sig_shift  = {r_wacc[23:0], b};
    assign seg_len    = {r_seg[15:8], b};
    assign seg_left   = seg_len - 16'd2;
    assign seg_dec    = r_seg - 16'd1;

    // Next state and result for the byte at the input
    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_kind      = r_kind;
        n_wacc      = r_wacc;
        n_hacc      = r_hacc;
        n_seg       = r_seg;
        n_sent      = r_sent;
        take_emit   = 1'b0;
        take_status = ST_OK;
        no_inc      = 1'b0;

        if (!r_sent) begin
            unique case (r_phase)
                PH_SIG: begin
                    n_wacc = sig_shift;
                    if (r_pos == 5'd2) begin
                        n_wacc = '0;
                        if (sig_shift[23:0] == SIG_GIF) begin
                            n_kind  = KIND_GIF;
                            n_phase = PH_GIF;
                        end else if (sig_shift[23:0] == SIG_JPEG) begin
                            n_kind  = KIND_JPEG;
                            n_phase = PH_J_MARK;
                        end else if (sig_shift[23:0] == SIG_PNG) begin
                            n_kind  = KIND_PNG;
                            n_phase = PH_PNG_SIG;
                        end else begin
                            take_emit   = 1'b1;
                            take_status = ST_UNKNOWN;
                        end
                    end
                end
                PH_GIF: begin
                    // little-endian width then height
                    if (r_pos == 5'd6) begin
                        n_wacc = {24'd0, b};
                    end else if (r_pos == 5'd7) begin
                        n_wacc = {r_wacc[31:16], b, r_wacc[7:0]};
                    end else if (r_pos == 5'd8) begin
                        n_hacc = {24'd0, b};
                    end else if (r_pos == 5'd9) begin
                        n_hacc      = {r_hacc[31:16], b, r_hacc[7:0]};
                        take_emit   = 1'b1;
                        take_status = ST_OK;
                    end
                end
                PH_PNG_SIG: begin
                    if (b != png_sig_byte(r_pos[2:0])) begin
                        take_emit   = 1'b1;
                        take_status = ST_PNG_BAD;
                    end else if (r_pos >= 5'd7) begin
                        n_phase = PH_PNG_DIM;
                    end
                end
                PH_PNG_DIM: begin
                    // big-endian width at 16..19, height at 20..23
                    if (r_pos >= 5'd16 && r_pos <= 5'd19) begin
                        n_wacc = {r_wacc[23:0], b};
                    end else if (r_pos >= 5'd20 && r_pos <= 5'd23) begin
                        n_hacc = {r_hacc[23:0], b};
                        if (r_pos == 5'd23) begin
                            take_emit   = 1'b1;
                            take_status = ST_OK;
                        end
                    end
                end
                PH_J_SEEK: begin
                    if (b == MK_FILL) begin
                        n_phase = PH_J_MARK;
                    end
                end
                PH_J_MARK: begin
                    if (b == MK_FILL) begin
                        n_phase = PH_J_MARK;   // fill byte
                    end else if (is_sof(b)) begin
                        n_phase = PH_J_SOF;
                        n_pos   = '0;
                        no_inc  = 1'b1;
                    end else if (b == MK_SOS || b == MK_EOI) begin
                        take_emit   = 1'b1;
                        take_status = ST_NO_FRAME;
                    end else begin
                        n_phase = PH_J_LEN_HI;
                    end
                end
                PH_J_LEN_HI: begin
                    n_seg   = {b, 8'd0};
                    n_phase = PH_J_LEN_LO;
                end
                PH_J_LEN_LO: begin
                    // length counts its own two bytes
                    if (seg_len < 16'd2) begin
                        take_emit   = 1'b1;
                        take_status = ST_BAD_LEN;
                    end else begin
                        n_seg   = seg_left;
                        n_phase = (seg_left != 16'd0) ? PH_J_SKIP : PH_J_SEEK;
                    end
                end
                PH_J_SKIP: begin
                    n_seg = seg_dec;
                    if (seg_dec == 16'd0) begin
                        n_phase = PH_J_SEEK;
                    end
                end
                PH_J_SOF: begin
                    // length (2) and precision (1), then height and width
                    if (r_pos == 5'd3) begin
                        n_hacc = {16'd0, b, 8'd0};
                    end else if (r_pos == 5'd4) begin
                        n_hacc = {r_hacc[31:8], b};
                    end else if (r_pos == 5'd5) begin
                        n_wacc = {16'd0, b, 8'd0};
                    end else if (r_pos == 5'd6) begin
                        n_wacc      = {r_wacc[31:8], b};
                        take_emit   = 1'b1;
                        take_status = ST_OK;
                    end
                end
                default: begin
                    n_phase = r_phase;     // finished: ignore bytes
                end
            endcase

            if (!no_inc && r_pos < 5'd31) begin
                n_pos = r_pos + 5'd1;
            end
        end

        if (take_emit) begin
            n_sent  = 1'b1;
            n_phase = PH_DONE;
        end

        // End of file forces a result when none went out
        fire = take_emit || (i_s_tlast && !n_sent);
        if (take_emit) begin
            fire_status = take_status;
        end else if (n_phase == PH_J_SEEK || n_phase == PH_J_MARK) begin
            fire_status = ST_NO_FRAME;
        end else begin
            fire_status = ST_TRUNC;
        end
        res_kind   = n_kind;
        res_width  = (fire_status == ST_OK) ? n_wacc : 32'd0;
        res_height = (fire_status == ST_OK) ? n_hacc : 32'd0;

        // New file after the last byte
        if (i_s_tlast) begin
            n_phase = PH_SIG;
            n_pos   = '0;
            n_kind  = KIND_NONE;
            n_wacc  = '0;
            n_hacc  = '0;
            n_seg   = '0;
            n_sent  = 1'b0;
        end
    end

    // Result register occupancy
    always_comb begin
        n_out_valid = (r_out_valid && !i_m_tready) || (acc && fire);
    end

    // Parser state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIG;
            r_pos       <= '0;
            r_kind      <= KIND_NONE;
            r_wacc      <= '0;
            r_hacc      <= '0;
            r_seg       <= '0;
            r_sent      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_kind  <= n_kind;
                r_wacc  <= n_wacc;
                r_hacc  <= n_hacc;
                r_seg   <= n_seg;
                r_sent  <= n_sent;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (acc && fire) begin
            r_out_status <= fire_status;
            r_out_kind   <= res_kind;
            r_out_width  <= res_width;
            r_out_height <= res_height;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_BYTES*8 - OUT_BITS){1'b0}},
                         r_out_height, r_out_width, r_out_kind, r_out_status};

endmodule

`default_nettype wire

// File: src/imsz_checker.sv
// Port-level checks for the image size header parser, bound to the top level.
`default_nettype none
`include "image_size_header_parser_defines.svh"

module imsz_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              o_s_tready,
    input wire                              o_m_tvalid,
    input wire                              i_m_tready,
    input wire [imsz_pkg::OUT_BYTES*8-1:0]  o_m_tdata
);
    import imsz_pkg::*;

    // stalled result keeps its place and payload
    `IMSZ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata))

    // input only stalls behind a blocked result
    `IMSZ_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !o_s_tready,
        o_m_tvalid && !i_m_tready)

    // failed parses carry zero dimensions
    `IMSZ_ASSERT_NOW(a_err_zero, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tdata[2:0] != ST_OK),
        (o_m_tdata[36:5] == 32'd0) && (o_m_tdata[68:37] == 32'd0))

    // status stays in its defined range, unknown kind never succeeds
    `IMSZ_ASSERT_NOW(a_status_range, i_clk, i_rst_n, o_m_tvalid,
        (o_m_tdata[2:0] <= ST_BAD_LEN)
        && !((o_m_tdata[4:3] == KIND_NONE) && (o_m_tdata[2:0] == ST_OK)))

endmodule

bind image_size_header_parser imsz_checker u_imsz_checker (.*);

`default_nettype wire
